// ----- hdl/cgtq_pkg.sv -----
// Package for the credit gated transmit queue.
// Holds the operation codes, the command beat and the result beat types.
// No dependencies.
package cgtq_pkg;

  // Operation codes of an input beat.
  typedef enum logic [1:0] {
    OP_ARRIVE = 2'd0,
    OP_EXPIRE = 2'd1,
    OP_STOP   = 2'd2,
    OP_GRANT  = 2'd3
  } op_e;

  // Command queue between the front and the back.
  localparam int unsigned CMD_DEPTH = 4;
  localparam int unsigned CMD_PTR_W = 2;
  localparam int unsigned CMD_CNT_W = 3;

  // Field widths fixed by the interface.
  localparam int unsigned DUR_W    = 16;
  localparam int unsigned CREDIT_W = 16;
  localparam int unsigned LIMIT_W  = 9;
  localparam int unsigned LEVEL_W  = 9;

  // One classified command: the operation and its one meaningful operand.
  typedef struct packed {
    op_e              kind;
    logic [DUR_W-1:0] value;
  } cmd_t;

  // One result beat.
  typedef struct packed {
    logic                sent_valid;
    logic [DUR_W-1:0]    sent_duration;
    logic                dropped;
    logic                start_timer;
    logic [DUR_W-1:0]    timer_delay;
    logic [LEVEL_W-1:0]  queue_level;
    logic [CREDIT_W-1:0] credits_left;
  } res_t;

endpackage

// ----- hdl/cgtq_front.sv -----
// Front end of the credit gated transmit queue: accepts input beats,
// classifies them into commands and buffers them in a small command queue.
// Depends on cgtq_pkg.
module cgtq_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push_i,
  output logic                        full_o,
  input  logic [1:0]                  operation_i,
  input  logic [cgtq_pkg::DUR_W-1:0]  packet_duration_i,
  input  logic [cgtq_pkg::DUR_W-1:0]  granted_credits_i,
  output cgtq_pkg::cmd_t              cmd_o,
  output logic                        cmd_valid_o,
  input  logic                        cmd_take_i
);
  import cgtq_pkg::*;

  cmd_t                 cmd_q [CMD_DEPTH];
  logic [CMD_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [CMD_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CMD_CNT_W-1:0] count_q, count_d;
  cmd_t                 new_cmd;
  logic                 wr_en;
  logic                 rd_en;

  // Classify the beat: keep only the operand that the operation uses.
  always_comb begin
    new_cmd.kind = op_e'(operation_i);
    case (new_cmd.kind)
      OP_ARRIVE: new_cmd.value = packet_duration_i;
      OP_GRANT:  new_cmd.value = granted_credits_i;
      default:   new_cmd.value = '0;
    endcase
  end

  // Queue handshake.
  assign full_o      = (count_q == CMD_CNT_W'(CMD_DEPTH));
  assign cmd_valid_o = (count_q != '0);
  assign cmd_o       = cmd_q[rd_ptr_q];
  assign wr_en       = push_i && !full_o;
  assign rd_en       = cmd_take_i && cmd_valid_o;

  // Pointer and count updates; the depth is a power of two, so pointers wrap.
  always_comb begin
    wr_ptr_d = wr_en ? wr_ptr_q + CMD_PTR_W'(1) : wr_ptr_q;
    rd_ptr_d = rd_en ? rd_ptr_q + CMD_PTR_W'(1) : rd_ptr_q;
    count_d  = count_q;
    if (wr_en && !rd_en) begin
      count_d = count_q + CMD_CNT_W'(1);
    end else if (rd_en && !wr_en) begin
      count_d = count_q - CMD_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Command storage.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      cmd_q[wr_ptr_q] <= new_cmd;
    end
  end

  // The fill count never passes the queue depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CMD_CNT_W'(CMD_DEPTH))
    else $error("command queue count exceeds its depth");

endmodule

// ----- hdl/cgtq_back.sv -----
// Back end of the credit gated transmit queue: packet store, credit and
// timer state, command execution and the result register.
// Depends on cgtq_pkg.
module cgtq_back #(
  parameter int unsigned DEPTH = 256
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [cgtq_pkg::LIMIT_W-1:0]  cfg_wdata_i,
  input  cgtq_pkg::cmd_t                cmd_i,
  input  logic                          cmd_valid_i,
  output logic                          cmd_take_o,
  output cgtq_pkg::res_t                res_o,
  output logic                          res_valid_o,
  input  logic                          res_pop_i
);
  import cgtq_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned OCC_W = $clog2(DEPTH + 1);
  localparam int unsigned CMP_W = OCC_W + LIMIT_W + 1;

  // Sequencer states: run executes commands, send waits for the head read.
  localparam logic ST_RUN  = 1'b0;
  localparam logic ST_SEND = 1'b1;

  logic [DUR_W-1:0]    mem_q [DEPTH];
  logic [DUR_W-1:0]    rd_data_q;
  logic [PTR_W-1:0]    head_q, head_d;
  logic [PTR_W-1:0]    tail_q, tail_d;
  logic [OCC_W-1:0]    occ_q, occ_d;
  logic [CREDIT_W-1:0] credit_q, credit_d;
  logic                stopped_q, stopped_d;
  logic                busy_q, busy_d;
  logic                state_q, state_d;
  logic [LIMIT_W-1:0]  limit_q;
  res_t                out_q, out_d;
  logic                out_valid_q;
  logic                can_load;
  logic                load_en;
  logic                wr_en;
  logic                rd_en;
  logic [CMP_W-1:0]    lim_ext;
  logic [CMP_W-1:0]    lim_eff;
  logic [CMP_W-1:0]    occ_ext;
  logic [CMP_W-1:0]    occ_d_ext;
  logic [CMP_W-1:0]    occ_q_ext;

  // Effective drop limit: the smaller of the register and the store depth.
  assign lim_ext   = CMP_W'(limit_q);
  assign lim_eff   = (lim_ext > CMP_W'(DEPTH)) ? CMP_W'(DEPTH) : lim_ext;
  assign occ_ext   = CMP_W'(occ_q);
  assign occ_q_ext = CMP_W'(occ_q);
  assign occ_d_ext = CMP_W'(occ_d);

  assign can_load    = !out_valid_q || res_pop_i;
  assign res_o       = out_q;
  assign res_valid_o = out_valid_q;

  // Command execution.
  always_comb begin
    head_d     = head_q;
    tail_d     = tail_q;
    occ_d      = occ_q;
    credit_d   = credit_q;
    stopped_d  = stopped_q;
    busy_d     = busy_q;
    state_d    = state_q;
    out_d      = '0;
    load_en    = 1'b0;
    wr_en      = 1'b0;
    rd_en      = 1'b0;
    cmd_take_o = 1'b0;
    case (state_q)
      ST_RUN: begin
        if (cmd_valid_i && can_load) begin
          cmd_take_o = 1'b1;
          load_en    = 1'b1;
          case (cmd_i.kind)
            OP_ARRIVE: begin
              if (occ_ext >= lim_eff) begin
                out_d.dropped = 1'b1;
              end else begin
                wr_en  = 1'b1;
                tail_d = (tail_q == PTR_W'(DEPTH - 1)) ? '0 : tail_q + PTR_W'(1);
                occ_d  = occ_q + OCC_W'(1);
                if (!busy_q && !stopped_q) begin
                  busy_d            = 1'b1;
                  out_d.start_timer = 1'b1;
                end
              end
            end
            OP_EXPIRE: begin
              busy_d = 1'b0;
              if (occ_q != '0 && credit_q != '0) begin
                // Send: read the head now, build the result in the send state.
                rd_en    = 1'b1;
                load_en  = 1'b0;
                head_d   = (head_q == PTR_W'(DEPTH - 1)) ? '0 : head_q + PTR_W'(1);
                occ_d    = occ_q - OCC_W'(1);
                credit_d = credit_q - CREDIT_W'(1);
                busy_d   = !stopped_q;
                state_d  = ST_SEND;
              end
            end
            OP_STOP: begin
              stopped_d = 1'b1;
            end
            OP_GRANT: begin
              stopped_d = 1'b0;
              credit_d  = cmd_i.value;
            end
            default: begin
              load_en = 1'b0;
            end
          endcase
          out_d.queue_level  = occ_d_ext[LEVEL_W-1:0];
          out_d.credits_left = credit_d;
        end
      end
      ST_SEND: begin
        if (can_load) begin
          load_en             = 1'b1;
          out_d.sent_valid    = 1'b1;
          out_d.sent_duration = rd_data_q;
          out_d.start_timer   = !stopped_q;
          out_d.timer_delay   = stopped_q ? '0 : rd_data_q;
          out_d.queue_level   = occ_q_ext[LEVEL_W-1:0];
          out_d.credits_left  = credit_q;
          state_d             = ST_RUN;
        end
      end
      default: begin
        state_d = ST_RUN;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      tail_q      <= '0;
      occ_q       <= '0;
      credit_q    <= '0;
      stopped_q   <= 1'b0;
      busy_q      <= 1'b0;
      state_q     <= ST_RUN;
      limit_q     <= LIMIT_W'(256);
      out_valid_q <= 1'b0;
    end else begin
      head_q    <= head_d;
      tail_q    <= tail_d;
      occ_q     <= occ_d;
      credit_q  <= credit_d;
      stopped_q <= stopped_d;
      busy_q    <= busy_d;
      state_q   <= state_d;
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
      if (load_en) begin
        out_valid_q <= 1'b1;
      end else if (res_pop_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    if (load_en) begin
      out_q <= out_d;
    end
  end

  // Packet store with a registered read of the head entry.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[tail_q] <= cmd_i.value;
    end
    if (rd_en) begin
      rd_data_q <= mem_q[head_q];
    end
  end

  // Occupancy never exceeds the store depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    CMP_W'(occ_q) <= CMP_W'(DEPTH))
    else $error("occupancy exceeds store depth");

  // A send leaves the send state with a sent result in the output register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SEND) && can_load |=> out_valid_q && out_q.sent_valid)
    else $error("send did not produce a sent result");

  // Entering the send state spends exactly one credit and one queue entry.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN) && rd_en |=>
      (state_q == ST_SEND) && (credit_q == $past(credit_q) - CREDIT_W'(1)) &&
      (occ_q == $past(occ_q) - OCC_W'(1)))
    else $error("send bookkeeping mismatch");

endmodule

// ----- hdl/credit_gated_tx_queue_top.sv -----
// Top level of the credit gated transmit queue.
// Instantiates cgtq_front and cgtq_back; depends on cgtq_pkg.
//
// Transmit queue whose sends are gated by receiver credits. Every input beat
// (arrival, timer expiry, stop, credit grant) yields exactly one result beat.
// Input beats are taken at one per cycle while the four-entry command queue
// is not full. While results are not being popped, four beats queue up behind
// a waiting result, so a burst of five is accepted when the result register
// starts empty. The back end executes one command per cycle while its output
// register can be loaded; an expiry that sends a packet also waits in the send
// state, as the head entry comes out of the packet store via a registered read
// port. A result passes the command queue and the output register (a sending
// expiry also the read port) before it is popped. A single output register
// holds the oldest result. Needing no store clearing, it is ready out of reset.
// buffer_limit may be written only while the block is idle; it resets to 256.
module credit_gated_tx_queue_top #(
  parameter int unsigned DEPTH = 256
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push,
  output logic                         full,
  input  logic                         pop,
  output logic                         empty,
  input  logic                         cfg_we_i,
  input  logic [cgtq_pkg::LIMIT_W-1:0] cfg_wdata_i,
  input  logic [1:0]                   operation_i,
  input  logic [15:0]                  packet_duration_i,
  input  logic [15:0]                  granted_credits_i,
  output logic                         sent_valid_o,
  output logic [15:0]                  sent_duration_o,
  output logic                         dropped_o,
  output logic                         start_timer_o,
  output logic [15:0]                  timer_delay_o,
  output logic [8:0]                   queue_level_o,
  output logic [15:0]                  credits_left_o
);
  import cgtq_pkg::*;

  cmd_t cmd;
  logic cmd_valid;
  logic cmd_take;
  res_t res;
  logic res_valid;

  // Front: classify and buffer input beats.
  cgtq_front u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .push_i            (push),
    .full_o            (full),
    .operation_i       (operation_i),
    .packet_duration_i (packet_duration_i),
    .granted_credits_i (granted_credits_i),
    .cmd_o             (cmd),
    .cmd_valid_o       (cmd_valid),
    .cmd_take_i        (cmd_take)
  );

  // Back: execute commands and hold the result.
  cgtq_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (cmd),
    .cmd_valid_i (cmd_valid),
    .cmd_take_o  (cmd_take),
    .res_o       (res),
    .res_valid_o (res_valid),
    .res_pop_i   (pop)
  );

  // Result ports.
  assign empty           = !res_valid;
  assign sent_valid_o    = res.sent_valid;
  assign sent_duration_o = res.sent_duration;
  assign dropped_o       = res.dropped;
  assign start_timer_o   = res.start_timer;
  assign timer_delay_o   = res.timer_delay;
  assign queue_level_o   = res.queue_level;
  assign credits_left_o  = res.credits_left;

endmodule
